@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl files (included by wsfp_core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define WSFP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wsfp assertion failed");

// condition that must never be seen outside reset
`define WSFP_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("wsfp forbidden condition seen");

`else

`define WSFP_ASSERT(lbl, clk, rstn, prop)
`define WSFP_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ hdl/wsfp_pkg.sv @@
`timescale 1ns / 1ps

package wsfp_pkg;

    // parser phase, codes five to seven never appear
    typedef enum logic [2:0] {
        PH_BYTE0  = 3'd0,
        PH_BYTE1  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    localparam logic       KIND_HEADER = 1'b0;
    localparam logic       KIND_DATA   = 1'b1;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    typedef struct packed {
        logic        kind;
        logic        fin_flag;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [63:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

@@ hdl/wsfp_in_reg.sv @@
`timescale 1ns / 1ps

module wsfp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // free slot, or the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hdl/wsfp_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_emit,
    output wsfp_pkg::t_result o_result
);

    wsfp_pkg::t_phase r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [2:0]  r_rsv, n_rsv;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic [3:0]  r_btc, n_btc;
    logic [63:0] r_length, n_length;
    logic [63:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_key_index, n_key_index;

    logic        after_len;
    logic        finish;
    logic        last;
    logic [7:0]  key_byte;
    logic [3:0]  btc_dec;

    assign btc_dec = r_btc - 4'd1;

    always_comb begin
        unique case (r_key_index)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_fin        = r_fin;
        n_rsv        = r_rsv;
        n_opcode     = r_opcode;
        n_mask       = r_mask;
        n_btc        = r_btc;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        n_key        = r_key;
        n_key_index  = r_key_index;
        after_len    = 1'b0;
        finish       = 1'b0;
        last         = 1'b0;
        o_emit       = 1'b0;

        unique case (r_phase)
            wsfp_pkg::PH_BYTE1: begin
                n_mask   = i_byte[7];
                n_length = 64'd0;
                if (i_byte[6:0] == wsfp_pkg::LEN_CODE_16) begin
                    n_btc   = wsfp_pkg::EXT_BYTES_16;
                    n_phase = wsfp_pkg::PH_EXTLEN;
                end else if (i_byte[6:0] == wsfp_pkg::LEN_CODE_64) begin
                    n_btc   = wsfp_pkg::EXT_BYTES_64;
                    n_phase = wsfp_pkg::PH_EXTLEN;
                end else begin
                    n_length  = {57'd0, i_byte[6:0]};
                    after_len = 1'b1;
                end
            end
            wsfp_pkg::PH_EXTLEN: begin
                n_length  = {r_length[55:0], i_byte};
                n_btc     = btc_dec;
                after_len = (btc_dec == 4'd0);
            end
            wsfp_pkg::PH_KEY: begin
                n_key  = {r_key[23:0], i_byte};
                n_btc  = btc_dec;
                finish = (btc_dec == 4'd0);
            end
            wsfp_pkg::PH_DATA: begin
                n_key_index  = r_key_index + 2'd1;
                n_bytes_left = r_bytes_left - 64'd1;
                last         = (r_bytes_left == 64'd1);
                o_emit       = 1'b1;
                if (last) begin
                    n_phase = wsfp_pkg::PH_BYTE0;
                end
            end
            default: begin
                n_fin       = i_byte[7];
                n_rsv       = i_byte[6:4];
                n_opcode    = i_byte[3:0];
                n_mask      = 1'b0;
                n_length    = 64'd0;
                n_key_index = 2'd0;
                n_phase     = wsfp_pkg::PH_BYTE1;
            end
        endcase

        // length known: key next if masked
        if (after_len) begin
            if (n_mask) begin
                n_key   = 32'd0;
                n_btc   = wsfp_pkg::KEY_BYTES;
                n_phase = wsfp_pkg::PH_KEY;
            end else begin
                finish = 1'b1;
            end
        end

        // header complete
        if (finish) begin
            o_emit = 1'b1;
            if (n_length == 64'd0) begin
                last    = 1'b1;
                n_phase = wsfp_pkg::PH_BYTE0;
            end else begin
                n_bytes_left = n_length;
                n_key_index  = 2'd0;
                n_phase      = wsfp_pkg::PH_DATA;
            end
        end
    end

    // result fields
    always_comb begin
        o_result.kind           = (r_phase == wsfp_pkg::PH_DATA) ? wsfp_pkg::KIND_DATA
                                                                 : wsfp_pkg::KIND_HEADER;
        o_result.fin_flag       = n_fin;
        o_result.reserved_bits  = n_rsv;
        o_result.frame_opcode   = n_opcode;
        o_result.masked_flag    = n_mask;
        o_result.payload_length = n_length;
        o_result.data_byte      = (r_phase == wsfp_pkg::PH_DATA)
                                  ? (i_byte ^ (r_mask ? key_byte : 8'd0)) : 8'd0;
        o_result.last           = last;
    end

    // a byte that makes no result never waits on the output side
    assign o_take = i_valid && (!o_emit || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wsfp_pkg::PH_BYTE0;
            r_fin        <= 1'b0;
            r_rsv        <= 3'd0;
            r_opcode     <= 4'd0;
            r_mask       <= 1'b0;
            r_btc        <= 4'd0;
            r_length     <= 64'd0;
            r_bytes_left <= 64'd0;
            r_key        <= 32'd0;
            r_key_index  <= 2'd0;
        end else if (o_take) begin
            r_phase      <= n_phase;
            r_fin        <= n_fin;
            r_rsv        <= n_rsv;
            r_opcode     <= n_opcode;
            r_mask       <= n_mask;
            r_btc        <= n_btc;
            r_length     <= n_length;
            r_bytes_left <= n_bytes_left;
            r_key        <= n_key;
            r_key_index  <= n_key_index;
        end
    end

    `WSFP_ASSERT(a_data_emits, i_clk, i_rst_n, (i_valid && r_phase == wsfp_pkg::PH_DATA) |-> o_emit)
    `WSFP_ASSERT(a_collect_nonzero, i_clk, i_rst_n, (r_phase == wsfp_pkg::PH_EXTLEN || r_phase == wsfp_pkg::PH_KEY) |-> (r_btc != 4'd0))
    `WSFP_NEVER(a_data_count_zero, i_clk, i_rst_n, r_phase == wsfp_pkg::PH_DATA && r_bytes_left == 64'd0)

endmodule

@@ hdl/wsfp_out_reg.sv @@
`timescale 1ns / 1ps

module wsfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsfp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output wsfp_pkg::t_result o_result
);

    logic              r_valid;
    wsfp_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/websocket_frame_parser.sv @@
`timescale 1ns / 1ps

// websocket receive deframer: takes the frame stream one byte per item, starting at a
// frame boundary after reset, and gives one header item when a frame header (flags,
// opcode, 7/16/64-bit length, optional masking key) is complete, then one item per
// payload byte with the mask removed; the last item of each frame has o_last set and a
// zero-length frame ends on its header item. other header, length and key bytes give no item.
// one byte is taken every cycle unless the output side stalls: a byte is held in the input
// register, the parse state updates from it in a single pass, and the result is loaded into
// the output register, from which it leaves when i_out_ready is high. stalls on the output
// side only hold back bytes that would produce a result. no opcode or length checks are made.

module websocket_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // parsed items out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic        o_fin_flag,
    output logic [2:0]  o_reserved_bits,
    output logic [3:0]  o_frame_opcode,
    output logic        o_masked_flag,
    output logic [63:0] o_payload_length,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    logic              stg_valid;
    logic [7:0]        stg_byte;
    logic              take;
    logic              emit;
    logic              out_free;
    wsfp_pkg::t_result core_result;
    wsfp_pkg::t_result out_result;

    // input register
    wsfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_rx_byte),
        .i_take  (take),
        .o_ready (o_in_ready),
        .o_valid (stg_valid),
        .o_byte  (stg_byte)
    );

    // header parse, length and key collection, unmasking
    wsfp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid),
        .i_byte     (stg_byte),
        .i_out_free (out_free),
        .o_take     (take),
        .o_emit     (emit),
        .o_result   (core_result)
    );

    // result register, loaded only when the byte produces an item
    wsfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (core_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_fin_flag       = out_result.fin_flag;
    assign o_reserved_bits  = out_result.reserved_bits;
    assign o_frame_opcode   = out_result.frame_opcode;
    assign o_masked_flag    = out_result.masked_flag;
    assign o_payload_length = out_result.payload_length;
    assign o_data_byte      = out_result.data_byte;
    assign o_last           = out_result.last;

endmodule

@@ tb/websocket_frame_parser_test.sv @@
`timescale 1ns / 1ps

module websocket_frame_parser_test;

    // length encodings a generated frame header can use
    localparam int FORM_7  = 0;
    localparam int FORM_16 = 1;
    localparam int FORM_64 = 2;

    localparam int RANDOM_BYTES = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 30;

    typedef struct {
        logic [7:0]        rx;
        bit                typed;
        wsfp_pkg::t_result want;
    } t_byte_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic        o_fin_flag;
    logic [2:0]  o_reserved_bits;
    logic [3:0]  o_frame_opcode;
    logic        o_masked_flag;
    logic [63:0] o_payload_length;
    logic [7:0]  o_data_byte;
    logic        o_last;

    websocket_frame_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_fin_flag       (o_fin_flag),
        .o_reserved_bits  (o_reserved_bits),
        .o_frame_opcode   (o_frame_opcode),
        .o_masked_flag    (o_masked_flag),
        .o_payload_length (o_payload_length),
        .o_data_byte      (o_data_byte),
        .o_last           (o_last)
    );

    always #2 i_clk = ~i_clk;

    t_byte_row         directed_rows [0:24];
    t_byte_row         byte_stream_q [$];
    wsfp_pkg::t_result frame_items_q [$];
    int                mismatches = 0;
    int                cycle_count = 0;

    // deframer state as the stream has left it so far
    wsfp_pkg::t_phase st_phase = wsfp_pkg::PH_BYTE0;
    logic        hdr_fin    = 1'b0;
    logic [2:0]  hdr_rsv    = 3'd0;
    logic [3:0]  hdr_op     = 4'd0;
    logic        hdr_masked = 1'b0;
    logic [3:0]  fill_count = 4'd0;
    logic [63:0] frame_len  = 64'd0;
    logic [63:0] remaining  = 64'd0;
    logic [31:0] mask_key   = 32'd0;
    logic [1:0]  key_pos    = 2'd0;

    function automatic wsfp_pkg::t_result frame_item(logic kind, logic [7:0] data,
                                                     logic last);
        wsfp_pkg::t_result r;
        r.kind           = kind;
        r.fin_flag       = hdr_fin;
        r.reserved_bits  = hdr_rsv;
        r.frame_opcode   = hdr_op;
        r.masked_flag    = hdr_masked;
        r.payload_length = frame_len;
        r.data_byte      = data;
        r.last           = last;
        return r;
    endfunction

    // header complete: empty frames end here, others go on to the payload
    function automatic bit header_done(output wsfp_pkg::t_result r);
        if (frame_len == 64'd0) begin
            r = frame_item(wsfp_pkg::KIND_HEADER, 8'h00, 1'b1);
            st_phase = wsfp_pkg::PH_BYTE0;
        end else begin
            r = frame_item(wsfp_pkg::KIND_HEADER, 8'h00, 1'b0);
            remaining = frame_len;
            key_pos = 2'd0;
            st_phase = wsfp_pkg::PH_DATA;
        end
        return 1'b1;
    endfunction

    function automatic bit length_known(output wsfp_pkg::t_result r);
        r = '0;
        if (hdr_masked) begin
            mask_key = 32'd0;
            fill_count = wsfp_pkg::KEY_BYTES;
            st_phase = wsfp_pkg::PH_KEY;
            return 1'b0;
        end
        return header_done(r);
    endfunction

    // advance the deframer by one byte, tell whether an item comes out
    function automatic bit deframe_byte(input logic [7:0] b, output wsfp_pkg::t_result r);
        logic [6:0] code;
        logic [7:0] kb;
        bit         got;
        r = '0;
        got = 1'b0;
        case (st_phase)
            wsfp_pkg::PH_BYTE1: begin
                code = b[6:0];
                hdr_masked = b[7];
                frame_len = 64'd0;
                if (code == wsfp_pkg::LEN_CODE_16) begin
                    fill_count = wsfp_pkg::EXT_BYTES_16;
                    st_phase = wsfp_pkg::PH_EXTLEN;
                end else if (code == wsfp_pkg::LEN_CODE_64) begin
                    fill_count = wsfp_pkg::EXT_BYTES_64;
                    st_phase = wsfp_pkg::PH_EXTLEN;
                end else begin
                    frame_len = {57'd0, code};
                    got = length_known(r);
                end
            end
            wsfp_pkg::PH_EXTLEN: begin
                frame_len = {frame_len[55:0], b};
                fill_count = fill_count - 4'd1;
                if (fill_count == 4'd0) got = length_known(r);
            end
            wsfp_pkg::PH_KEY: begin
                mask_key = {mask_key[23:0], b};
                fill_count = fill_count - 4'd1;
                if (fill_count == 4'd0) got = header_done(r);
            end
            wsfp_pkg::PH_DATA: begin
                kb = hdr_masked ? mask_key[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
                key_pos = key_pos + 2'd1;
                remaining = remaining - 64'd1;
                r = frame_item(wsfp_pkg::KIND_DATA, b ^ kb, remaining == 64'd0);
                if (remaining == 64'd0) st_phase = wsfp_pkg::PH_BYTE0;
                got = 1'b1;
            end
            default: begin
                hdr_fin = b[7];
                hdr_rsv = b[6:4];
                hdr_op = b[3:0];
                hdr_masked = 1'b0;
                frame_len = 64'd0;
                key_pos = 2'd0;
                st_phase = wsfp_pkg::PH_BYTE1;
            end
        endcase
        return got;
    endfunction

    // typed-in item for the directed table
    function automatic wsfp_pkg::t_result known_item(logic kind, logic fin, logic [2:0] rsv,
                                                     logic [3:0] op, logic masked,
                                                     logic [63:0] len, logic [7:0] data,
                                                     logic last);
        wsfp_pkg::t_result r;
        r = {kind, fin, rsv, op, masked, len, data, last};
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) report(name, got, want);
    endtask

    task automatic queue_byte(logic [7:0] b);
        t_byte_row row;
        row.rx = b;
        row.typed = 1'b0;
        row.want = '0;
        byte_stream_q.push_back(row);
    endtask

    // one frame with random flags, key and payload; payload may be cut short
    task automatic queue_frame(int form, logic [63:0] len, bit masked, longint max_payload);
        logic [6:0] code;
        longint     n;
        code = (form == FORM_16) ? wsfp_pkg::LEN_CODE_16 :
               (form == FORM_64) ? wsfp_pkg::LEN_CODE_64 : len[6:0];
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte({masked, code});
        if (form == FORM_16) begin
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
        end else if (form == FORM_64) begin
            for (int i = 7; i >= 0; i--) queue_byte(len[8 * i +: 8]);
        end
        if (masked) repeat (4) queue_byte(8'($urandom_range(0, 255)));
        n = (len > 64'(max_payload)) ? max_payload : longint'(len);
        for (longint i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    endtask

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // byte sender: bursts of random length separated by random gaps
    int burst_left = 20;
    int gap_left = 0;

    always @(posedge i_clk) begin
        wsfp_pkg::t_result r;
        bit                has_item;
        t_byte_row         cur;
        bit                hold;
        if (i_rst_n) begin
            hold = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                has_item = deframe_byte(i_rx_byte, r);
                cur = byte_stream_q.pop_front();
                if (cur.typed) frame_items_q.push_back(cur.want);
                else if (has_item) frame_items_q.push_back(r);
            end
            if (!hold) begin
                if (gap_left != 0) begin
                    i_in_valid <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (byte_stream_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte <= byte_stream_q[0].rx;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: the stall pattern is picked anew at random from four modes as cycle_count advances
    int stall_mode = 0;

    always @(posedge i_clk) begin
        if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (cycle_count % 5 != 0);
        endcase
    end

    // result checker against the oldest expected item
    always @(posedge i_clk) begin
        wsfp_pkg::t_result got;
        wsfp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_kind, o_fin_flag, o_reserved_bits, o_frame_opcode, o_masked_flag,
                   o_payload_length, o_data_byte, o_last};
            if (frame_items_q.size() == 0) begin
                report("item with nothing expected", got.payload_length, 64'd0);
            end else begin
                want = frame_items_q.pop_front();
                check_field("kind", 64'(got.kind), 64'(want.kind));
                check_field("fin_flag", 64'(got.fin_flag), 64'(want.fin_flag));
                check_field("reserved_bits", 64'(got.reserved_bits),
                            64'(want.reserved_bits));
                check_field("frame_opcode", 64'(got.frame_opcode), 64'(want.frame_opcode));
                check_field("masked_flag", 64'(got.masked_flag), 64'(want.masked_flag));
                check_field("payload_length", got.payload_length, want.payload_length);
                check_field("data_byte", 64'(got.data_byte), 64'(want.data_byte));
                check_field("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    initial begin
        int     sel;
        int     form;
        bit     masked;
        longint len;

        // empty frame, empty frame in 16-bit form with all reserved bits set,
        // one masked byte, and a 64-bit length with two plain bytes
        directed_rows = '{
            '{8'h81, 1'b0, '0},
            '{8'h00, 1'b1, known_item(wsfp_pkg::KIND_HEADER, 1'b1, 3'd0, 4'h1, 1'b0,
                                      64'd0, 8'h00, 1'b1)},
            '{8'h7f, 1'b0, '0},
            '{8'h7e, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, known_item(wsfp_pkg::KIND_HEADER, 1'b0, 3'd7, 4'hf, 1'b0,
                                      64'd0, 8'h00, 1'b1)},
            '{8'h02, 1'b0, '0},
            '{8'h81, 1'b0, '0},
            '{8'hff, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hff, 1'b0, '0},
            '{8'h00, 1'b1, known_item(wsfp_pkg::KIND_HEADER, 1'b0, 3'd0, 4'h2, 1'b1,
                                      64'd1, 8'h00, 1'b0)},
            '{8'haa, 1'b1, known_item(wsfp_pkg::KIND_DATA, 1'b0, 3'd0, 4'h2, 1'b1,
                                      64'd1, 8'h55, 1'b1)},
            '{8'h80, 1'b0, '0},
            '{8'h7f, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h02, 1'b1, known_item(wsfp_pkg::KIND_HEADER, 1'b1, 3'd0, 4'h0, 1'b0,
                                      64'd2, 8'h00, 1'b0)},
            '{8'h00, 1'b0, '0},
            '{8'hff, 1'b0, '0}
        };
        foreach (directed_rows[i]) byte_stream_q.push_back(directed_rows[i]);

        // random frames, mostly short, some in the long length forms
        while (byte_stream_q.size() < RANDOM_BYTES + 25) begin
            sel = $urandom_range(0, 99);
            masked = 1'($urandom_range(0, 1));
            if (sel < 8) begin
                form = $urandom_range(FORM_7, FORM_64);
                len = 0;
            end else if (sel < 65) begin
                form = FORM_7;
                len = (sel < 13) ? $urandom_range(100, 125) : $urandom_range(1, 24);
            end else if (sel < 78) begin
                form = FORM_16;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 300)
                                                  : $urandom_range(0, 60);
            end else begin
                form = FORM_64;
                len = $urandom_range(0, 40);
            end
            queue_frame(form, 64'(len), masked, len);
        end
        // a frame of the largest length, only its first bytes are sent
        queue_frame(FORM_64, '1, 1'b1, 24);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream_q.size() != 0) @(posedge i_clk);
        while (frame_items_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
